// File: src/sorted_min_priority_queue_assert.svh
// Assertion macros for the sorted minimum priority queue.
// Depends on nothing; included by the top level only.
`ifndef SORTED_MIN_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_MIN_PRIORITY_QUEUE_ASSERT_SVH

// Same-cycle implication checked at every clock edge outside reset.
`define SPQ_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define SPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/spq_pkg.sv
// Shared types and codes of the sorted minimum priority queue.
// Depends on nothing; imported by spq_cell, the top level, spq_checker and tb_top.
package spq_pkg;

	localparam int DATA_W = 32;
	localparam int STAT_W = 2;
	localparam int OCC_W  = 5;

	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

	// Per-cell control from the top level.
	typedef struct packed {
		logic push_en; // insert the pushed value this cycle
		logic pop_en;  // shift everything one cell toward the head
		logic occ;     // cell holds a stored value
		logic at_end;  // cell is the first free one
	} cell_ctl_t;

endpackage

// File: src/spq_cell.sv
// One cell of the sorted chain: holds one entry and trades with its neighbors.
// Depends on spq_pkg.
module spq_cell import spq_pkg::*; (
	input  logic              clk,
	input  cell_ctl_t         ctl,
	input  logic [DATA_W-1:0] val,
	input  logic              left_gt,
	input  logic [DATA_W-1:0] left_entry,
	input  logic [DATA_W-1:0] right_entry,
	output logic [DATA_W-1:0] entry,
	output logic              gt
);

	logic [DATA_W-1:0] entry_q;

	assign entry = entry_q;
	assign gt    = ctl.occ && (entry_q > val);

	always_ff @(posedge clk) begin
		if (ctl.push_en) begin
			// larger entries move one cell up; the value lands at the boundary
			if (left_gt) begin
				entry_q <= left_entry;
			end else if (gt || ctl.at_end) begin
				entry_q <= val;
			end
		end else if (ctl.pop_en) begin
			entry_q <= right_entry;
		end
	end

endmodule

// File: src/sorted_min_priority_queue.sv
// Top level of the sorted minimum priority queue: cell chain, count, output register.
// Depends on spq_pkg, spq_cell and sorted_min_priority_queue_assert.svh.
//
//  channel | dir | tdata                         | tuser
//  s_axis  | in  | [31:0] value                  | [0] opcode (0 push, 1 pop)
//  m_axis  | out | [31:0] popped_value, [36:32] occupancy, zero pad | [1:0] status
//
// One transfer in per cycle while s_tready is high; each result is registered and valid
// in the cycle after its transfer, as every cell takes a single compare-and-shift step.
// The output register frees s_tready whenever it is empty or being taken.
// A stalled m_tready holds the result and drops s_tready.
// Reset clears the count and the output valid; cell contents stay undefined.
module sorted_min_priority_queue import spq_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // [31:0] value
	input  logic        s_tuser,  // [0] opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // [31:0] popped_value, [36:32] occupancy, [39:37] zero
	output logic [1:0]  m_tuser   // [1:0] status
);

	localparam int CW = $clog2(DEPTH + 1);

	logic [CW-1:0]     count_q;
	logic [CW-1:0]     count_nxt;
	logic [CW+OCC_W-1:0] occ_wide;
	logic              in_acc;
	logic              full;
	logic              empty;
	logic              push_ok;
	logic              pop_ok;

	logic [DATA_W-1:0] entry [DEPTH];
	logic              gt    [DEPTH];
	cell_ctl_t         ctl   [DEPTH];

	logic              m_tvalid_q;
	logic [DATA_W-1:0] popped_q;
	logic [STAT_W-1:0] status_q;
	logic [OCC_W-1:0]  occ_q;

	assign s_tready = !m_tvalid_q || m_tready;
	assign in_acc   = s_tvalid && s_tready;
	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);
	assign push_ok  = in_acc && (s_tuser == OP_PUSH) && !full;
	assign pop_ok   = in_acc && (s_tuser == OP_POP) && !empty;

	always_comb begin
		count_nxt = count_q;
		if (push_ok) begin
			count_nxt = count_q + 1'b1;
		end else if (pop_ok) begin
			count_nxt = count_q - 1'b1;
		end
	end

	assign occ_wide = {{OCC_W{1'b0}}, count_nxt};

	genvar i;
	generate
		for (i = 0; i < DEPTH; i++) begin : g_cell
			logic              lgt;
			logic [DATA_W-1:0] lent;
			logic [DATA_W-1:0] rent;

			assign ctl[i].push_en = push_ok;
			assign ctl[i].pop_en  = pop_ok;
			assign ctl[i].occ     = (CW'(i) < count_q);
			assign ctl[i].at_end  = (CW'(i) == count_q);

			if (i == 0) begin : g_head
				assign lgt  = 1'b0;
				assign lent = s_tdata;
			end else begin : g_body
				assign lgt  = gt[i-1];
				assign lent = entry[i-1];
			end

			if (i == DEPTH - 1) begin : g_tail
				assign rent = entry[i];
			end else begin : g_mid
				assign rent = entry[i+1];
			end

			spq_cell u_cell (
				.clk         (clk),
				.ctl         (ctl[i]),
				.val         (s_tdata),
				.left_gt     (lgt),
				.left_entry  (lent),
				.right_entry (rent),
				.entry       (entry[i]),
				.gt          (gt[i])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			count_q <= count_nxt;
			if (in_acc) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			popped_q <= pop_ok ? entry[0] : '0;
			occ_q    <= occ_wide[OCC_W-1:0];
			if (s_tuser == OP_PUSH) begin
				status_q <= full ? ST_FULL : ST_OK;
			end else begin
				status_q <= empty ? ST_EMPTY : ST_OK;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {3'b000, occ_q, popped_q};
	assign m_tuser  = status_q;

`include "sorted_min_priority_queue_assert.svh"

	`SPQ_ASSERT_SAME(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(DEPTH), "count above depth")
	`SPQ_ASSERT_NEXT(a_push_grows, clk, arst_n, push_ok, count_q == $past(count_q) + 1'b1, "push did not grow count")
	`SPQ_ASSERT_SAME(a_head_sorted, clk, arst_n, count_q >= CW'(2), entry[0] <= entry[1], "head entries out of order")
	`SPQ_ASSERT_SAME(a_empty_zero, clk, arst_n, m_tvalid_q && status_q == ST_EMPTY, popped_q == '0 && occ_q == '0, "empty pop with payload")

endmodule

// File: dv/spq_checker.sv
// Checker for the sorted minimum priority queue: watches both stream channels,
// keeps its own sorted copy of the queue and compares every result.
// Depends on spq_pkg for field widths, opcodes and status codes.
module spq_checker import spq_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,  // [31:0] value
	input  logic        s_tuser,  // [0] opcode
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [39:0] m_tdata,  // [31:0] popped_value, [36:32] occupancy, [39:37] zero
	input  logic [1:0]  m_tuser,  // [1:0] status
	output int          mismatch_count,
	output int          results_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [DATA_W-1:0] popped;
		logic [STAT_W-1:0] status;
		logic [OCC_W-1:0]  occupancy;
	} queue_result_t;

	logic [DATA_W-1:0] held_vals[DEPTH];
	int                held_count;
	queue_result_t     awaited_q[$];
	int                mismatch_total;

	assign mismatch_count = mismatch_total;

	// Apply one push or pop to the held copy and return what the block must answer.
	function automatic queue_result_t apply_item(input logic op, input logic [DATA_W-1:0] val);
		queue_result_t r;
		int            i;
		r.popped = '0;
		r.status = ST_OK;
		if (op == OP_PUSH) begin
			if (held_count >= DEPTH) begin
				r.status = ST_FULL;
			end else begin
				// shift larger values up; equal ones stay ahead of the new value
				i = held_count;
				while (i > 0 && held_vals[i-1] > val) begin
					held_vals[i] = held_vals[i-1];
					i--;
				end
				held_vals[i] = val;
				held_count++;
			end
		end else if (held_count == 0) begin
			r.status = ST_EMPTY;
		end else begin
			r.popped = held_vals[0];
			for (i = 1; i < held_count; i++)
				held_vals[i-1] = held_vals[i];
			held_count--;
		end
		r.occupancy = OCC_W'(held_count);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		queue_result_t want;
		if (!arst_n) begin
			held_count = 0;
			awaited_q.delete();
			mismatch_total = 0;
			results_pending <= 0;
		end else begin
			// check the result first: it can never belong to this edge's input transfer
			if (m_tvalid && m_tready) begin
				if (awaited_q.size() == 0) begin
					mismatch_total++;
					if (mismatch_total <= 10)
						$display("[%0t] result with none awaited: popped %h status %0d occ %0d",
							$realtime, m_tdata[31:0], m_tuser, m_tdata[36:32]);
				end else begin
					want = awaited_q.pop_front();
					if (m_tdata[31:0] !== want.popped || m_tuser !== want.status ||
					    m_tdata[36:32] !== want.occupancy || m_tdata[39:37] !== 3'b000) begin
						mismatch_total++;
						if (mismatch_total <= 10)
							$display(
								"[%0t] exp/act popped %h/%h status %0d/%0d occ %0d/%0d pad 0/%0h",
								$realtime,
								want.popped, m_tdata[31:0], want.status, m_tuser,
								want.occupancy, m_tdata[36:32], m_tdata[39:37]);
					end
				end
			end
			if (s_tvalid && s_tready)
				awaited_q.push_back(apply_item(s_tuser, s_tdata));
			results_pending <= awaited_q.size();
		end
	end

endmodule

// File: dv/tb_top.sv
// Testbench top for the sorted minimum priority queue: clock, reset, stimulus,
// output backpressure and verdict. Depends on spq_pkg, the RTL and spq_checker.
module tb_top import spq_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH        = 16;
	localparam int PHASE_ITEMS  = 475;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 20;
	localparam int CYCLE_LIMIT  = 200000;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata  = '0;
	logic        s_tuser  = OP_PUSH;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic [1:0]  m_tuser;

	int mismatch_count;
	int results_pending;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int cycle_count   = 0;
	bit hold_req      = 1'b0;

	always #4 clk = ~clk;

	sorted_min_priority_queue #(.DEPTH(DEPTH)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	spq_checker #(.DEPTH(DEPTH)) u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.mismatch_count(mismatch_count), .results_pending(results_pending)
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Receiver: random backpressure, plus one long hold-off on request.
	initial begin
		bit hold_done;
		hold_done = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
				@(posedge clk);
			end
		end
	end

	// Offer one item with random leading gaps and hold it until the transfer.
	task automatic send_item(input logic op, input logic [31:0] val);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= val;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (results_pending != 0) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(7))
			0, 1:    return $urandom_range(7);   // many duplicates
			2:       return '1 - $urandom_range(3);
			3:       return 32'h8000_0000 ^ $urandom_range(1);
			default: return $urandom;
		endcase
	endfunction

	// Random walk over occupancy: segments lean toward filling, draining or neither.
	task automatic run_phase(input int items, input bit with_hold);
		int sent;
		int seg_left;
		int push_pct;
		sent     = 0;
		seg_left = 0;
		push_pct = 50;
		while (sent < items) begin
			if (seg_left == 0) begin
				seg_left = $urandom_range(40, 10);
				case ($urandom_range(3))
					0:       push_pct = 15;
					1:       push_pct = 50;
					2:       push_pct = 85;
					default: push_pct = 97;
				endcase
			end
			if (with_hold && sent == items / 2)
				hold_req <= 1'b1;
			send_item(($urandom_range(99) < push_pct) ? OP_PUSH : OP_POP, pick_value());
			seg_left--;
			sent++;
		end
	endtask

	initial begin
		logic [31:0] corner_vals[16];
		corner_vals = '{32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h0000_0001, 32'hFFFF_FFFE, 32'hAAAA_AAAA, 32'h5555_5555,
			32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0001,
			32'h7FFF_FFFF, 32'h1234_5678, 32'hFFFF_FFFF, 32'h0000_0000};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: pop on empty, fill with corner values, push on full, partial drain
		send_item(OP_POP, 32'hFFFF_FFFF);
		foreach (corner_vals[i])
			send_item(OP_PUSH, corner_vals[i]);
		send_item(OP_PUSH, 32'h0000_0000);
		repeat (7) send_item(OP_POP, $urandom);
		wait_drained();

		send_idle_pct = 31;
		recv_idle_pct = 80;
		run_phase(PHASE_ITEMS, 1'b0);
		// pause the sender until every result is back
		wait_drained();

		send_idle_pct = 80;
		recv_idle_pct = 31;
		run_phase(PHASE_ITEMS, 1'b0);
		wait_drained();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_phase(PHASE_ITEMS, 1'b1);

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && results_pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
